// ===== src/gb3_pkg.sv =====
// ----------------------------------------------------------------------------
// gb3_pkg: shared types and constants of the 3x3 Gaussian blur
// Widths, the line memory word, the window column and the border flags that
// travel from the line-buffer front end to the kernel datapath.
// ----------------------------------------------------------------------------
package gb3_pkg;

    // Largest supported image side, and widths derived from it.
    localparam int MAX_SIDE = 4096;
    localparam int SIDE_MIN = 3;
    localparam int CFG_W    = 13;
    localparam int PIX_W    = 8;
    localparam int COL_W    = $clog2(MAX_SIDE);
    // Row counter reaches side + 1 during the drain of the last row.
    localparam int CNT_W    = $clog2(MAX_SIDE + 2);
    localparam int CMP_W    = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    // Kernel arithmetic: weights sum to 16, so the sum needs four more bits.
    localparam int SUM_W       = PIX_W + 4;
    localparam int FULL_MAX    = 16 * ((1 << PIX_W) - 1);
    localparam int CORNER_MAX  = 9 * ((1 << PIX_W) - 1);
    // Division by 9 as a multiply by ceil(2^16 / 9) and a shift by 16.
    localparam int RECIP_SHIFT = 16;
    localparam int RECIP_W     = 13;
    localparam int RECIP9      = ((1 << RECIP_SHIFT) + 8) / 9;
    localparam int PROD_W      = SUM_W + RECIP_W;

    // Output queue that decouples the pipeline from the result sink.
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    typedef logic [PIX_W-1:0] t_pix;

    // One window column, index 0 is the top row.
    typedef t_pix [2:0] t_col;

    // Full 3x3 window, indexed by column.
    typedef t_col [2:0] t_win;

    // One line memory word: the pixel two rows up and the one a row up.
    typedef struct packed {
        t_pix upper;
        t_pix middle;
    } t_line_word;

    // Border position of the pixel being filtered, plus end-of-frame mark.
    typedef struct packed {
        logic top;
        logic bot;
        logic left;
        logic right;
        logic last;
    } t_edge;

    // One result beat.
    typedef struct packed {
        t_pix pixel;
        logic last;
    } t_result;

    typedef enum logic {
        REQ_PIXEL = 1'b0,
        REQ_FLUSH = 1'b1
    } t_req;

endpackage

// ===== src/gb3_in_if.sv =====
// ----------------------------------------------------------------------------
// gb3_in_if: input pixel stream
// Valid/ready channel carrying one raw pixel or one flush request per beat.
// ----------------------------------------------------------------------------
interface gb3_in_if;
    logic          valid;
    logic          ready;
    logic          req_type;
    gb3_pkg::t_pix pixel_in;

    modport source (output valid, output req_type, output pixel_in, input ready);
    modport sink   (input valid, input req_type, input pixel_in, output ready);
endinterface

// ===== src/gb3_out_if.sv =====
// ----------------------------------------------------------------------------
// gb3_out_if: filtered pixel stream
// Valid/ready channel carrying one filtered pixel and its end-of-frame mark.
// ----------------------------------------------------------------------------
interface gb3_out_if;
    logic          valid;
    logic          ready;
    gb3_pkg::t_pix pixel_out;
    logic          frame_last;

    modport source (output valid, output pixel_out, output frame_last, input ready);
    modport sink   (input valid, input pixel_out, input frame_last, output ready);
endinterface

// ===== src/gb3_kernel.sv =====
// ----------------------------------------------------------------------------
// gb3_kernel: border fix-up, weighted sum and scaling
// Two registered stages: the window is latched with its border flags, then
// the weighted sum is formed, then the sum is divided by 16 or by 9.
// ----------------------------------------------------------------------------
module gb3_kernel (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  gb3_pkg::t_col        i_col_l,
    input  gb3_pkg::t_col        i_col_c,
    input  gb3_pkg::t_col        i_col_r,
    input  gb3_pkg::t_edge       i_edge,
    output logic [1:0]           o_busy,
    output logic                 o_push,
    output gb3_pkg::t_result     o_result
);

    logic                        r_s2_valid;
    gb3_pkg::t_win               r_s2_win;
    gb3_pkg::t_edge              r_s2_edge;

    logic                        r_s3_valid;
    logic [gb3_pkg::SUM_W-1:0]   r_s3_sum;
    logic                        r_s3_corner;
    logic                        r_s3_last;

    gb3_pkg::t_win               g;
    logic                        corner;
    gb3_pkg::t_pix               c_h;
    gb3_pkg::t_pix               c_v;
    gb3_pkg::t_pix               c_d;
    logic [gb3_pkg::SUM_W-1:0]   full_sum;
    logic [gb3_pkg::SUM_W-1:0]   corner_sum;
    logic [gb3_pkg::PROD_W-1:0]  prod;

    // Window latch.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= i_valid;
        end
        r_s2_win[0] <= i_col_l;
        r_s2_win[1] <= i_col_c;
        r_s2_win[2] <= i_col_r;
        r_s2_edge   <= i_edge;
    end

    // Replace missing neighbors by the nearest edge pixel, rows first.
    always_comb begin
        g = r_s2_win;
        if (r_s2_edge.top) begin
            for (int k = 0; k < 3; k++) g[k][0] = g[k][1];
        end
        if (r_s2_edge.bot) begin
            for (int k = 0; k < 3; k++) g[k][2] = g[k][1];
        end
        if (r_s2_edge.left) begin
            g[0] = g[1];
        end
        if (r_s2_edge.right) begin
            g[2] = g[1];
        end
    end

    // Corners weight the center by 4, its two inner neighbors by 2 and the
    // inner diagonal by 1.
    assign corner = (r_s2_edge.top | r_s2_edge.bot) & (r_s2_edge.left | r_s2_edge.right);
    assign c_h    = r_s2_edge.left ? g[2][1] : g[0][1];
    assign c_v    = r_s2_edge.top  ? g[1][2] : g[1][0];
    assign c_d    = r_s2_edge.left ? (r_s2_edge.top ? g[2][2] : g[2][0])
                                   : (r_s2_edge.top ? g[0][2] : g[0][0]);

    assign corner_sum = (gb3_pkg::SUM_W'(g[1][1]) << 2) + (gb3_pkg::SUM_W'(c_h) << 1)
                      + (gb3_pkg::SUM_W'(c_v) << 1) + gb3_pkg::SUM_W'(c_d);

    assign full_sum = gb3_pkg::SUM_W'(g[0][0]) + (gb3_pkg::SUM_W'(g[1][0]) << 1)
                    + gb3_pkg::SUM_W'(g[2][0]) + (gb3_pkg::SUM_W'(g[0][1]) << 1)
                    + (gb3_pkg::SUM_W'(g[1][1]) << 2) + (gb3_pkg::SUM_W'(g[2][1]) << 1)
                    + gb3_pkg::SUM_W'(g[0][2]) + (gb3_pkg::SUM_W'(g[1][2]) << 1)
                    + gb3_pkg::SUM_W'(g[2][2]);

    // Sum register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else begin
            r_s3_valid <= r_s2_valid;
        end
        r_s3_sum    <= corner ? corner_sum : full_sum;
        r_s3_corner <= corner;
        r_s3_last   <= r_s2_edge.last;
    end

    // Scaling: a shift for 16, a reciprocal multiply for 9.
    assign prod = gb3_pkg::PROD_W'(r_s3_sum) * gb3_pkg::PROD_W'(gb3_pkg::RECIP9);

    always_comb begin
        o_result.last = r_s3_last;
        if (r_s3_corner) begin
            o_result.pixel = prod[gb3_pkg::RECIP_SHIFT +: gb3_pkg::PIX_W];
        end else begin
            o_result.pixel = r_s3_sum[gb3_pkg::SUM_W-1 -: gb3_pkg::PIX_W];
        end
    end

    assign o_push = r_s3_valid;
    assign o_busy = {1'b0, r_s2_valid} + {1'b0, r_s3_valid};

    // A corner sum stays within nine full-scale pixels.
    a_corner_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s3_valid && r_s3_corner) |-> (r_s3_sum <= gb3_pkg::SUM_W'(gb3_pkg::CORNER_MAX)))
        else $error("corner sum out of range");

    // A full sum stays within sixteen full-scale pixels.
    a_full_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s3_valid && !r_s3_corner) |-> (r_s3_sum <= gb3_pkg::SUM_W'(gb3_pkg::FULL_MAX)))
        else $error("kernel sum out of range");

    // The reciprocal product never carries above the pixel width.
    a_quot_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s3_valid && r_s3_corner)
            |-> (prod[gb3_pkg::PROD_W-1:gb3_pkg::RECIP_SHIFT+gb3_pkg::PIX_W] == '0))
        else $error("corner quotient overflow");

endmodule

// ===== src/gb3_out_fifo.sv =====
// ----------------------------------------------------------------------------
// gb3_out_fifo: result queue
// Small register queue that holds finished results until the sink takes
// them; its fill count feeds the input credit check.
// ----------------------------------------------------------------------------
module gb3_out_fifo (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    input  gb3_pkg::t_result            i_result,
    output logic [gb3_pkg::FIFO_CW-1:0] o_count,
    gb3_out_if.source                   o_out
);

    gb3_pkg::t_result               r_mem [gb3_pkg::FIFO_DEPTH];
    logic [gb3_pkg::FIFO_AW-1:0]    r_wr_ptr;
    logic [gb3_pkg::FIFO_AW-1:0]    r_rd_ptr;
    logic [gb3_pkg::FIFO_CW-1:0]    r_count;
    logic                           pop;

    assign pop = o_out.valid & o_out.ready;

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + gb3_pkg::FIFO_AW'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + gb3_pkg::FIFO_AW'(1);
            end
            if (i_push && !pop) begin
                r_count <= r_count + gb3_pkg::FIFO_CW'(1);
            end else if (!i_push && pop) begin
                r_count <= r_count - gb3_pkg::FIFO_CW'(1);
            end
        end
    end

    // Storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_result;
        end
    end

    assign o_out.valid      = (r_count != '0);
    assign o_out.pixel_out  = r_mem[r_rd_ptr].pixel;
    assign o_out.frame_last = r_mem[r_rd_ptr].last;
    assign o_count          = r_count;

    // The credit check upstream never lets a result arrive at a full queue.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_count < gb3_pkg::FIFO_CW'(gb3_pkg::FIFO_DEPTH)))
        else $error("result queue overflow");

    // Fill count stays within the depth.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= gb3_pkg::FIFO_CW'(gb3_pkg::FIFO_DEPTH))
        else $error("result queue count out of range");

    // A result pushed into an empty queue is offered on the next cycle.
    a_push_visible: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && (r_count == '0)) |=> o_out.valid)
        else $error("pushed result not offered");

endmodule

// ===== src/gaussian_blur_3x3.sv =====
// ----------------------------------------------------------------------------
// gaussian_blur_3x3: streaming 3x3 Gaussian blur of a square grey image
// Line-buffer front end, kernel datapath and result queue.
// ----------------------------------------------------------------------------
// The block takes one beat per clock while input ready is high, and gives at
// most one filtered pixel per input beat. Each beat does one read of a single
// line memory (MAX_SIDE words, each holding the pixels one and two rows up)
// and, outside the drain row, one write, so that memory port pair sets the
// rate of one pixel per cycle. A result passes the stage 1 registers, the
// window latch and the sum register and waits in an eight-entry queue; input
// ready drops only when that queue plus the results still in the pipeline
// would fill it. Results trail the input by one row plus one pixel, so after
// S*S image pixels the host sends S + 1 flush beats; the last result carries
// frame_last. The memory needs no clearing after reset. Writing side_length
// restarts the frame and is to be done by the user only while the block is idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module gaussian_blur_3x3 (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [gb3_pkg::CFG_W-1:0]  i_cfg_wdata,
    gb3_in_if.sink                     i_in,
    gb3_out_if.source                  o_out
);

    // Frame position and configuration.
    logic [gb3_pkg::CFG_W-1:0]   r_side;
    logic [gb3_pkg::CNT_W-1:0]   r_row;
    logic [gb3_pkg::COL_W-1:0]   r_col;
    logic [gb3_pkg::CNT_W-1:0]   n_row;
    logic [gb3_pkg::COL_W-1:0]   n_col;

    logic [gb3_pkg::CMP_W-1:0]   side_ext;
    logic [gb3_pkg::CNT_W-1:0]   s_eff;
    logic [gb3_pkg::CNT_W-1:0]   s_m1;
    logic [gb3_pkg::CNT_W-1:0]   s_p1;
    logic [gb3_pkg::CNT_W-1:0]   col_ext;

    logic                        accept;
    logic                        take_a;
    logic                        take_b;
    logic                        upd;
    logic [gb3_pkg::CNT_W-1:0]   res_row;
    logic [gb3_pkg::CNT_W-1:0]   res_col;
    gb3_pkg::t_edge              edge_flags;
    gb3_pkg::t_pix               pix_val;

    // Line memory stage.
    gb3_pkg::t_line_word         r_line_mem [gb3_pkg::MAX_SIDE];
    gb3_pkg::t_line_word         r_rd_word;
    logic                        r_s1_valid;
    logic                        r_s1_upd;
    logic                        r_s1_res;
    gb3_pkg::t_edge              r_s1_edge;
    gb3_pkg::t_pix               r_s1_pix;
    logic [gb3_pkg::COL_W-1:0]   r_s1_addr;

    // Window: the two most recent columns.
    gb3_pkg::t_col               r_win_mid;
    gb3_pkg::t_col               r_win_right;
    gb3_pkg::t_col               new_col;

    logic [1:0]                  kern_busy;
    logic                        kern_push;
    gb3_pkg::t_result            kern_result;
    logic [gb3_pkg::FIFO_CW-1:0] fifo_count;
    logic [gb3_pkg::FIFO_CW:0]   pending;

    // Side length saturated to the supported range.
    always_comb begin
        side_ext = gb3_pkg::CMP_W'(r_side);
        if (side_ext < gb3_pkg::CMP_W'(gb3_pkg::SIDE_MIN)) begin
            s_eff = gb3_pkg::CNT_W'(gb3_pkg::SIDE_MIN);
        end else if (side_ext > gb3_pkg::CMP_W'(gb3_pkg::MAX_SIDE)) begin
            s_eff = gb3_pkg::CNT_W'(gb3_pkg::MAX_SIDE);
        end else begin
            s_eff = gb3_pkg::CNT_W'(side_ext);
        end
    end

    assign s_m1    = s_eff - gb3_pkg::CNT_W'(1);
    assign s_p1    = s_eff + gb3_pkg::CNT_W'(1);
    assign col_ext = gb3_pkg::CNT_W'(r_col);

    // Input credit: queue fill plus every result still in the pipeline.
    assign pending = (gb3_pkg::FIFO_CW + 1)'(fifo_count)
                   + (gb3_pkg::FIFO_CW + 1)'(r_s1_res & r_s1_valid)
                   + (gb3_pkg::FIFO_CW + 1)'(kern_busy);
    assign i_in.ready = (pending < (gb3_pkg::FIFO_CW + 1)'(gb3_pkg::FIFO_DEPTH));
    assign accept     = i_in.valid & i_in.ready;

    // Result decode: a new row first emits the right-edge pixel two rows up,
    // otherwise a beat past the first column emits the pixel up and left.
    assign take_a = (r_col == '0) && (r_row >= gb3_pkg::CNT_W'(2)) && (r_row <= s_p1);
    assign upd    = (r_row <= s_eff);
    assign take_b = upd && (r_row != '0) && (r_col != '0);

    always_comb begin
        if (take_a) begin
            res_row = r_row - gb3_pkg::CNT_W'(2);
            res_col = s_m1;
        end else begin
            res_row = r_row - gb3_pkg::CNT_W'(1);
            res_col = col_ext - gb3_pkg::CNT_W'(1);
        end
        edge_flags.top   = (res_row == '0);
        edge_flags.bot   = (res_row == s_m1);
        edge_flags.left  = (res_col == '0);
        edge_flags.right = (res_col == s_m1);
        edge_flags.last  = take_a && (r_row == s_p1);
    end

    assign pix_val = (i_in.req_type == gb3_pkg::REQ_FLUSH) ? '0 : i_in.pixel_in;

    // Next frame position.
    always_comb begin
        if (r_row >= s_p1) begin
            n_row = '0;
            n_col = '0;
        end else if ((col_ext + gb3_pkg::CNT_W'(1)) >= s_eff) begin
            n_row = r_row + gb3_pkg::CNT_W'(1);
            n_col = '0;
        end else begin
            n_row = r_row;
            n_col = r_col + gb3_pkg::COL_W'(1);
        end
    end

    // Configuration and frame counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side <= gb3_pkg::CFG_W'(gb3_pkg::MAX_SIDE);
            r_row  <= '0;
            r_col  <= '0;
        end else if (i_cfg_we) begin
            r_side <= i_cfg_wdata;
            r_row  <= '0;
            r_col  <= '0;
        end else if (accept) begin
            r_row  <= n_row;
            r_col  <= n_col;
        end
    end

    // Stage 1 control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept;
        end
        r_s1_upd  <= upd;
        r_s1_res  <= take_a | take_b;
        r_s1_edge <= edge_flags;
        r_s1_pix  <= pix_val;
        r_s1_addr <= r_col;
    end

    // Line memory: read on accept, write back in the following cycle. Successive
    // beats use different columns, so the read never meets a pending write.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rd_word <= r_line_mem[r_col];
        end
        if (r_s1_valid && r_s1_upd) begin
            r_line_mem[r_s1_addr] <= '{upper: r_rd_word.middle, middle: r_s1_pix};
        end
    end

    // Incoming window column: two rows up, one row up, current row.
    always_comb begin
        new_col[0] = r_rd_word.upper;
        new_col[1] = r_rd_word.middle;
        new_col[2] = r_s1_pix;
    end

    // Window shift.
    always_ff @(posedge i_clk) begin
        if (r_s1_valid && r_s1_upd) begin
            r_win_mid   <= r_win_right;
            r_win_right <= new_col;
        end
    end

    gb3_kernel u_kernel (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_s1_valid & r_s1_res),
        .i_col_l  (r_win_mid),
        .i_col_c  (r_win_right),
        .i_col_r  (new_col),
        .i_edge   (r_s1_edge),
        .o_busy   (kern_busy),
        .o_push   (kern_push),
        .o_result (kern_result)
    );

    gb3_out_fifo u_out_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (kern_push),
        .i_result (kern_result),
        .o_count  (fifo_count),
        .o_out    (o_out)
    );

    // Results in flight never exceed the queue depth.
    a_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pending <= (gb3_pkg::FIFO_CW + 1)'(gb3_pkg::FIFO_DEPTH))
        else $error("results in flight exceed queue depth");

    // The row counter stops at the drain row.
    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_row <= s_p1)
        else $error("row counter beyond drain row");

    // The drain row is only ever entered at its first column.
    a_drain_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_row == s_p1) |-> (r_col == '0))
        else $error("drain row at nonzero column");

endmodule
